@@ hdl/swrl_pkg.sv @@
// Shared word types for the sliding-window rate limiter.
`default_nettype none

package swrl_pkg;

    localparam int unsigned TIME_W  = 48;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned LIMIT_W = 7;

    localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_RECORD = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_ms;
        logic [LIMIT_W-1:0] entries_in_window;
        logic               store_overflow;
    } out_word_t;

endpackage

`default_nettype wire

@@ hdl/swrl_ts_mem.sv @@
// Timestamp ring memory: one write port, one registered read port.
`default_nettype none

module swrl_ts_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6,
    parameter int unsigned DW    = 48
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hdl/swrl_engine.sv @@
// Sequencer: prunes, evaluates and records against the timestamp ring.
`default_nettype none

module swrl_engine #(
    parameter int unsigned MAX_ENTRIES = 64,
    parameter int unsigned WINDOW_MS   = 60000,
    parameter int unsigned PTR_W       = 6,
    parameter int unsigned CNT_W       = 7
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [swrl_pkg::LIMIT_W-1:0]  limit,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire swrl_pkg::in_word_t            s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output swrl_pkg::out_word_t                m_data,
    output logic                               mem_we,
    output logic [PTR_W-1:0]                   mem_waddr,
    output logic [swrl_pkg::TIME_W-1:0]        mem_wdata,
    output logic [PTR_W-1:0]                   mem_raddr,
    input  wire logic [swrl_pkg::TIME_W-1:0]   mem_rdata
);

    import swrl_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_REC  = 2'd1;
    localparam logic [1:0] ST_CHK  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam int unsigned SUM_W  = CNT_W + 1;
    localparam int unsigned CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int unsigned DIFF_W = TIME_W + 2;

    localparam logic [TIME_W-1:0] WIN_T    = TIME_W'(WINDOW_MS);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(MAX_ENTRIES - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_ENTRIES);
    localparam logic [SUM_W-1:0]  SUM_MAX  = SUM_W'(MAX_ENTRIES);

    logic [1:0]         state_reg,  state_next;
    logic [TIME_W-1:0]  now_reg,    now_next;
    logic [TIME_W-1:0]  cutoff_reg, cutoff_next;
    logic               early_reg,  early_next;
    logic [PTR_W-1:0]   oldest_reg, oldest_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [DIFF_W-1:0]  diff_reg,   diff_next;
    logic               m_valid_reg, m_valid_next;
    out_word_t          m_data_reg,  m_data_next;

    logic               out_free;
    logic               out_load;
    logic               prune_hit;
    logic               at_limit;
    logic               full;
    logic [PTR_W-1:0]   oldest_inc;
    logic [SUM_W-1:0]   tail_sum;
    logic [PTR_W-1:0]   tail_addr;
    logic [DELAY_W-1:0] delay_sat;

    assign out_free   = !m_valid_reg || m_ready;
    assign full       = (count_reg == CNT_FULL);
    assign at_limit   = (CMP_W'(count_reg) >= CMP_W'(limit));
    assign prune_hit  = (count_reg != '0) && !early_reg && (mem_rdata <= cutoff_reg);
    assign oldest_inc = (oldest_reg == PTR_LAST) ? '0 : oldest_reg + PTR_W'(1);
    assign tail_sum   = SUM_W'(oldest_reg) + SUM_W'(count_reg);
    assign tail_addr  = (tail_sum >= SUM_MAX) ? PTR_W'(tail_sum - SUM_MAX) : PTR_W'(tail_sum);

    // Positive difference saturates to 16 bits; zero or negative means no wait.
    always_comb begin
        if (diff_reg[DIFF_W-1] || diff_reg == '0) begin
            delay_sat = '0;
        end else if (diff_reg[DIFF_W-2:DELAY_W] != '0) begin
            delay_sat = DELAY_MAX;
        end else begin
            delay_sat = diff_reg[DELAY_W-1:0];
        end
    end

    always_comb begin
        state_next  = state_reg;
        now_next    = now_reg;
        cutoff_next = cutoff_reg;
        early_next  = early_reg;
        oldest_next = oldest_reg;
        count_next  = count_reg;
        diff_next   = diff_reg;
        out_load    = 1'b0;
        m_data_next = m_data_reg;
        mem_we      = 1'b0;
        mem_waddr   = tail_addr;
        mem_wdata   = now_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    now_next    = s_data.now_ms;
                    early_next  = (s_data.now_ms < WIN_T);
                    cutoff_next = s_data.now_ms - WIN_T;
                    state_next  = (s_data.cmd == CMD_RECORD) ? ST_REC : ST_CHK;
                end
            end
            ST_REC: begin
                if (out_free) begin
                    mem_we = 1'b1;
                    m_data_next.delay_ms = '0;
                    if (full) begin
                        mem_waddr   = oldest_reg;
                        oldest_next = oldest_inc;
                        m_data_next.store_overflow = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                        m_data_next.store_overflow = 1'b0;
                    end
                    m_data_next.entries_in_window = LIMIT_W'(count_next);
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CHK: begin
                if (prune_hit) begin
                    oldest_next = oldest_inc;
                    count_next  = count_reg - CNT_W'(1);
                end else begin
                    diff_next  = DIFF_W'(mem_rdata) + DIFF_W'(WIN_T) - DIFF_W'(now_reg);
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_data_next.delay_ms          = at_limit ? delay_sat : '0;
                    m_data_next.entries_in_window = LIMIT_W'(count_reg);
                    m_data_next.store_overflow    = 1'b0;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Read the entry that will be oldest next cycle.
    assign mem_raddr = oldest_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            oldest_reg  <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg    <= now_next;
        cutoff_reg <= cutoff_next;
        early_reg  <= early_next;
        diff_reg   <= diff_next;
        m_data_reg <= m_data_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("entry count above ring depth");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        oldest_reg <= PTR_LAST)
        else $error("oldest pointer outside ring");

    a_prune_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHK && prune_hit) |=>
            (count_reg == $past(count_reg) - CNT_W'(1)) && (state_reg == ST_CHK))
        else $error("prune did not retire exactly one entry");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && m_data_next.store_overflow) |-> (full && state_reg == ST_REC))
        else $error("overflow flagged without a full ring");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded over an untaken word");

endmodule

`default_nettype wire

@@ hdl/sliding_window_rate_limiter_top.sv @@
// Top level of the sliding-window rate limiter: config register, sequencer and ring.
// A record word goes from the record state into the output register; a query word
// stays in the check state while it drops expired timestamps, then the finish state
// loads its result. One word at a time; the record and finish states wait for a free
// output register, and the prune walk reads one ring entry per cycle.
// Reset (synchronous, aresetn low): ring empty, pointers zero, limit register 1.
`default_nettype none

module sliding_window_rate_limiter_top #(
    parameter int unsigned MAX_ENTRIES = 64,
    parameter int unsigned WINDOW_MS   = 60000
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [swrl_pkg::LIMIT_W-1:0] cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire swrl_pkg::in_word_t           s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output swrl_pkg::out_word_t               m_data
);

    import swrl_pkg::*;

    // Ring addressing and occupancy widths follow the ring depth.
    localparam int unsigned PTR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [LIMIT_W-1:0] max_per_window_reg;
    logic [LIMIT_W-1:0] limit;

    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    logic [TIME_W-1:0]  mem_wdata;
    logic [PTR_W-1:0]   mem_raddr;
    logic [TIME_W-1:0]  mem_rdata;

    // Send limit per window; user writes only while the block is idle (unenforced).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_per_window_reg <= LIMIT_W'(1);
        end else if (cfg_wr_en) begin
            max_per_window_reg <= cfg_wr_data;
        end
    end

    // A zero limit behaves as a limit of one.
    assign limit = (max_per_window_reg == '0) ? LIMIT_W'(1) : max_per_window_reg;

    // Sequencer: accepts a word; a query walks expired entries out of the ring and
    // computes the delay, a record appends the timestamp; the result waits in an
    // output register so the next word can be taken meanwhile.
    swrl_engine #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WINDOW_MS   (WINDOW_MS),
        .PTR_W       (PTR_W),
        .CNT_W       (CNT_W)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .limit     (limit),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Timestamp ring: only entries inside the live span affect a result, so it
    // needs no clearing after reset.
    swrl_ts_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (PTR_W),
        .DW    (TIME_W)
    ) u_ts_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the sliding-window rate limiter top level.
module tb;
    import swrl_pkg::*;

    // Block defaults; the predictor below mirrors them.
    localparam int unsigned DEPTH       = 64;
    localparam int unsigned WINDOW_MS   = 60000;
    localparam int unsigned IDX_W       = $clog2(DEPTH);
    // The tail wait outlasts the longest query, which walks every held stamp.
    localparam int unsigned TAIL_CYCLES = DEPTH + 8;
    localparam int unsigned SETTLE      = 4;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned STUCK_LIMIT = 5000;
    localparam int unsigned SEG_WORDS   = 234;
    localparam int unsigned NO_HOOK     = 32'hFFFF_FFFF;

    // Predicts each result word from the accepted input words and checks
    // the block's output against it, oldest first.
    class delay_ledger;
        logic [TIME_W-1:0]  stamps [DEPTH];
        logic [IDX_W-1:0]   head;
        logic [LIMIT_W-1:0] held;
        logic [LIMIT_W-1:0] limit_reg;
        out_word_t          owed_results [$];
        int unsigned        faults;

        function new();
            head      = '0;
            held      = '0;
            limit_reg = LIMIT_W'(1);
            faults    = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] v);
            limit_reg = v;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        function void log_word(in_word_t w);
            out_word_t          e;
            logic [63:0]        now64;
            logic [63:0]        due;
            logic [LIMIT_W-1:0] eff;
            logic [IDX_W-1:0]   slot;
            e     = '0;
            now64 = 64'(w.now_ms);
            if (w.cmd == CMD_QUERY) begin
                eff = (limit_reg == 0) ? LIMIT_W'(1) : limit_reg;
                // Drop expired stamps from the oldest end; stop at the first newer one.
                if (now64 >= WINDOW_MS) begin
                    while (held != 0 && 64'(stamps[head]) <= now64 - WINDOW_MS) begin
                        head = head + IDX_W'(1);
                        held = held - LIMIT_W'(1);
                    end
                end
                if (held >= eff) begin
                    due = 64'(stamps[head]) + WINDOW_MS;
                    if (due > now64) begin
                        if (due - now64 > 64'(DELAY_MAX))
                            e.delay_ms = DELAY_MAX;
                        else
                            e.delay_ms = DELAY_W'(due - now64);
                    end
                end
            end else begin
                if (held >= DEPTH) begin
                    stamps[head]     = w.now_ms;
                    head             = head + IDX_W'(1);
                    e.store_overflow = 1'b1;
                end else begin
                    slot         = head + IDX_W'(held);
                    stamps[slot] = w.now_ms;
                    held         = held + LIMIT_W'(1);
                end
            end
            e.entries_in_window = held;
            owed_results = {owed_results, e};
        endfunction

        function void match_result(out_word_t got);
            out_word_t e;
            if (owed_results.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result word: delay %0d entries %0d overflow %0b",
                             got.delay_ms, got.entries_in_window, got.store_overflow);
                return;
            end
            e = owed_results.pop_front();
            if (got.delay_ms !== e.delay_ms || got.entries_in_window !== e.entries_in_window ||
                got.store_overflow !== e.store_overflow) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: delay exp %0d got %0d, entries exp %0d got %0d, %s%0b got %0b",
                             e.delay_ms, got.delay_ms, e.entries_in_window,
                             got.entries_in_window, "overflow exp ", e.store_overflow,
                             got.store_overflow);
            end
        endfunction
    endclass

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    in_word_t           s_data      = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    out_word_t          m_data;

    delay_ledger        book;
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;
    logic               hold_call     = 1'b0;
    int unsigned        hold_left     = 0;
    int unsigned        stuck         = 0;
    logic [TIME_W-1:0]  clock_ms      = '0;

    sliding_window_rate_limiter_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #4 aclk = ~aclk;

    // Result side: stall at random, or hold off for a long stretch on request
    // so that the block backs up and stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_call) begin
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_call <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every accepted result word; end the run if nothing moves for too long.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            book.match_result(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stuck = 0;
        else
            stuck++;
        if (stuck >= STUCK_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one word, idling first at random, and log it on acceptance.
    // Valid stays high on return so a back-to-back word needs no drop.
    task automatic send_word(input logic cmd, input logic [TIME_W-1:0] t);
        in_word_t w;
        w.cmd    = cmd;
        w.now_ms = t;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        book.log_word(w);
    endtask

    // Drop valid and wait until every owed result word has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge aclk);
    endtask

    // Write the limit register while the block is idle.
    task automatic set_window_limit(input logic [LIMIT_W-1:0] v);
        drain();
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        book.set_limit(v);
        cfg_wr_en <= 1'b0;
    endtask

    // Random traffic in bursts of one style each: dense bursts fill and
    // overflow the store, steady and sparse ones exercise pruning, chaotic
    // ones jump the clock, run it backward and hit the upper time bits.
    // Each segment opens with a dense burst.
    task automatic run_segment(input int unsigned n_words, input int unsigned hold_at,
                               input int unsigned pause_at);
        int unsigned done;
        int unsigned style;
        int unsigned len;
        int unsigned rec_pct;
        int unsigned k;
        int unsigned pick;
        logic        cmd;
        done = 0;
        while (done < n_words) begin
            style = (done == 0) ? 0 : $urandom_range(99);
            if (style < 40)
                len = $urandom_range(60, 120);
            else if (style < 90)
                len = $urandom_range(10, 60);
            else
                len = $urandom_range(3, 12);
            for (k = 0; k < len && done < n_words; k++) begin
                if (style < 40) begin
                    clock_ms = clock_ms + TIME_W'($urandom_range(300));
                    rec_pct  = 75;
                end else if (style < 75) begin
                    clock_ms = clock_ms + TIME_W'($urandom_range(3000));
                    rec_pct  = 50;
                end else if (style < 90) begin
                    clock_ms = clock_ms + TIME_W'($urandom_range(20000, 90000));
                    rec_pct  = 40;
                end else begin
                    pick = $urandom_range(3);
                    case (pick)
                        0: clock_ms = {16'($urandom_range(16'hFFFF)), 32'($urandom)};
                        1: clock_ms = clock_ms - TIME_W'($urandom_range(40000));
                        2: clock_ms = clock_ms + TIME_W'($urandom_range(59000, 61000));
                        default: clock_ms = clock_ms;
                    endcase
                    rec_pct = 50;
                end
                cmd = ($urandom_range(99) < rec_pct) ? CMD_RECORD : CMD_QUERY;
                if (done == hold_at)
                    hold_call <= 1'b1;
                if (done == pause_at)
                    drain();
                send_word(cmd, clock_ms);
                done++;
            end
        end
    endtask

    initial begin
        book = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words under the reset limit of one.
        send_word(CMD_QUERY,  48'd0);         // empty store, early time
        send_word(CMD_RECORD, 48'd0);
        send_word(CMD_QUERY,  48'd1000);      // full for a limit of one
        send_word(CMD_QUERY,  48'd59999);     // cutoff still below zero
        send_word(CMD_QUERY,  48'd60000);     // cutoff zero drops the stamp at zero
        send_word(CMD_RECORD, 48'd60000);
        send_word(CMD_RECORD, 48'd70000);
        send_word(CMD_QUERY,  48'd65000);     // time runs backward
        send_word(CMD_RECORD, 48'd200000);
        send_word(CMD_QUERY,  48'd130001);    // delay beyond 16 bits saturates
        send_word(CMD_RECORD, 48'd100);
        send_word(CMD_QUERY,  48'd200000);    // prune stops at the newer stamp
        send_word(CMD_RECORD, 48'hFFFF_FFFF_FFFF);
        send_word(CMD_QUERY,  48'hFFFF_FFFF_FFFF);
        send_word(CMD_QUERY,  48'h0000_0000_EA60);

        // Sender idles 35 of a hundred, receiver 83; long receiver hold mid-way.
        send_idle_pct = 35;
        recv_idle_pct = 83;
        set_window_limit(7'd64);
        run_segment(SEG_WORDS, 100, NO_HOOK);
        set_window_limit(7'd0);
        run_segment(SEG_WORDS, NO_HOOK, NO_HOOK);

        // Swap the idling; pause the sender until the block empties once.
        send_idle_pct = 83;
        recv_idle_pct = 35;
        set_window_limit(7'd127);
        run_segment(SEG_WORDS, NO_HOOK, 120);
        set_window_limit(7'd5);
        run_segment(SEG_WORDS, NO_HOOK, NO_HOOK);

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_window_limit(7'd1);
        run_segment(SEG_WORDS, NO_HOOK, NO_HOOK);
        set_window_limit(7'($urandom_range(127)));
        run_segment(SEG_WORDS, NO_HOOK, NO_HOOK);

        // Flush, then watch for stray result words.
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (book.faults == 0 && book.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

@@ files.f @@
hdl/swrl_pkg.sv
hdl/swrl_ts_mem.sv
hdl/swrl_engine.sv
hdl/sliding_window_rate_limiter_top.sv
verif/tb.sv
